[sv/mf5_pkg.sv]
// Package for the 5x5 RGB median filter: shared constants and types.
// Used by the top level; has no dependencies.
package mf5_pkg;

    localparam int PIX_W          = 24;
    localparam int CH_W           = 8;
    localparam int CHANNELS       = 3;
    localparam int WIN            = 5;
    localparam int CELLS          = WIN * WIN;
    localparam int KEPT_ROWS      = WIN - 1;
    localparam int MEDIAN_RANK    = CELLS / 2;
    localparam int CFG_W          = 12;
    localparam int COL_W          = 12;
    localparam int ROW_W          = 3;
    localparam int MIN_WIDTH      = 5;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int FIFO_DEPTH     = 6;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd1024;

    typedef logic [PIX_W-1:0]           t_pix;
    typedef logic [KEPT_ROWS*PIX_W-1:0] t_col_word;
    typedef logic [CELLS-1:0]           t_rank_vec;

    typedef struct packed {
        logic [CH_W-1:0] med_red;
        logic [CH_W-1:0] med_green;
        logic [CH_W-1:0] med_blue;
        logic            row_end;
    } t_result;

endpackage

[sv/median_filter_5x5_rgb_top.sv]
// Beats pass the line store, window, compare and rank select stages. Throughput:
// one pixel per cycle while a queue credit is free; the line store is one 96-bit
// column word per column (read and written once per pixel), and a 6-entry
// result queue with credits decouples the output side. Synchronous active-low
// reset clears counters, window, pipeline valids and queue, not the line store.
// Top level of the 5x5 RGB median filter. Depends on mf5_pkg and mf5_ram.
module median_filter_5x5_rgb_top #(
    parameter int MAX_WIDTH = mf5_pkg::MAX_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [mf5_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [mf5_pkg::CH_W-1:0]   i_red,
    input  logic [mf5_pkg::CH_W-1:0]   i_green,
    input  logic [mf5_pkg::CH_W-1:0]   i_blue,
    input  logic                       i_first_of_frame,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [mf5_pkg::CH_W-1:0]   o_med_red,
    output logic [mf5_pkg::CH_W-1:0]   o_med_green,
    output logic [mf5_pkg::CH_W-1:0]   o_med_blue,
    output logic                       o_row_end
);
    import mf5_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW0 = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (WW0 > COL_W) ? WW0 : COL_W;
    localparam int FPW = $clog2(FIFO_DEPTH);
    localparam int FCW = $clog2(FIFO_DEPTH + 1);
    localparam logic [WW-1:0] MAX_W  = WW'(MAX_WIDTH);
    localparam logic [WW-1:0] MIN_W  = WW'(MIN_WIDTH);
    localparam logic [ROW_W-1:0] ROW_FULL = ROW_W'(KEPT_ROWS);
    localparam logic [COL_W-1:0] COL_FIRST_OUT = COL_W'(KEPT_ROWS);

    // ---------------- configuration and counters ----------------
    logic [CFG_W-1:0] r_width;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic             accept;
    logic [WW-1:0]    w_used;
    logic [WW-1:0]    cfg_ext;
    logic [COL_W-1:0] col_eff;
    logic [ROW_W-1:0] row_eff;
    logic [WW-1:0]    col_ext;
    logic [AW-1:0]    rd_addr;
    logic             emit;
    logic             last;
    t_pix             in_pix;

    assign accept  = i_in_valid && o_in_ready;
    assign in_pix  = {i_blue, i_green, i_red};
    assign cfg_ext = WW'(r_width);

    // Clamp the programmed width and decode the current position
    always_comb begin
        if (cfg_ext < MIN_W) begin
            w_used = MIN_W;
        end else if (cfg_ext > MAX_W) begin
            w_used = MAX_W;
        end else begin
            w_used = cfg_ext;
        end
        col_eff = i_first_of_frame ? '0 : r_col;
        row_eff = i_first_of_frame ? '0 : r_row;
        col_ext = WW'(col_eff);
        if (col_ext >= MAX_W) begin
            rd_addr = AW'(MAX_WIDTH - 1);
        end else begin
            rd_addr = col_ext[AW-1:0];
        end
        emit = (col_eff >= COL_FIRST_OUT) && (row_eff >= ROW_FULL);
        last = col_ext >= (w_used - WW'(1));
        if (last) begin
            n_col = '0;
            n_row = (row_eff < ROW_FULL) ? row_eff + ROW_W'(1) : row_eff;
        end else begin
            n_col = col_eff + COL_W'(1);
            n_row = row_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_width <= i_cfg_wr_data;
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // ---------------- line store stage ----------------
    logic          r_b_valid, r_b_emit, r_b_last, r_fwd;
    t_pix          r_b_pix;
    logic [AW-1:0] r_b_addr;
    t_col_word     r_fwd_word, rd_word, old_word, n_word;

    mf5_ram #(
        .WIDTH (KEPT_ROWS * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (r_b_valid),
        .i_wr_addr (r_b_addr),
        .i_wr_data (n_word),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_word)
    );

    // Bypass the column word written in the same cycle as the read
    assign old_word = r_fwd ? r_fwd_word : rd_word;
    assign n_word   = {old_word[(KEPT_ROWS-1)*PIX_W-1:0], r_b_pix};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_b_valid <= accept;
            r_fwd     <= accept && r_b_valid && (r_b_addr == rd_addr);
        end
        if (accept) begin
            r_b_pix  <= in_pix;
            r_b_addr <= rd_addr;
            r_b_emit <= emit;
            r_b_last <= last;
        end
        if (r_b_valid) begin
            r_fwd_word <= n_word;
        end
    end

    // ---------------- window stage ----------------
    t_pix r_win [CELLS];
    t_pix new_col [WIN];
    logic r_c_valid, r_c_last;

    always_comb begin
        for (int r = 0; r < KEPT_ROWS; r++) begin
            new_col[r] = old_word[(KEPT_ROWS-1-r)*PIX_W +: PIX_W];
        end
        new_col[WIN-1] = r_b_pix;
    end

    // Shift the window left, new column on the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                r_win[i] <= '0;
            end
            r_c_valid <= 1'b0;
        end else begin
            if (r_b_valid) begin
                for (int r = 0; r < WIN; r++) begin
                    for (int k = 0; k < WIN - 1; k++) begin
                        r_win[r*WIN+k] <= r_win[r*WIN+k+1];
                    end
                    r_win[r*WIN+WIN-1] <= new_col[r];
                end
            end
            r_c_valid <= r_b_valid && r_b_emit;
        end
        r_c_last <= r_b_last;
    end

    // ---------------- compare stage ----------------
    // A cell's bit j is set when cell j ranks below it (ties broken by index).
    t_rank_vec n_lt [CHANNELS][CELLS];
    t_rank_vec r_lt [CHANNELS][CELLS];
    t_pix      r_d_val [CELLS];
    logic      r_d_valid, r_d_last;

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            for (int i = 0; i < CELLS; i++) begin
                for (int j = 0; j < CELLS; j++) begin
                    n_lt[ch][i][j] =
                        (r_win[j][ch*CH_W +: CH_W] < r_win[i][ch*CH_W +: CH_W]) ||
                        ((r_win[j][ch*CH_W +: CH_W] == r_win[i][ch*CH_W +: CH_W]) &&
                         (j < i));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
        r_d_last <= r_c_last;
        r_lt     <= n_lt;
        r_d_val  <= r_win;
    end

    // ---------------- rank select stage ----------------
    localparam int RK_W = $clog2(CELLS + 1);
    t_result med;

    always_comb begin
        logic [CH_W-1:0] acc [CHANNELS];
        for (int ch = 0; ch < CHANNELS; ch++) begin
            acc[ch] = '0;
            for (int i = 0; i < CELLS; i++) begin
                if (RK_W'($countones(r_lt[ch][i])) == RK_W'(MEDIAN_RANK)) begin
                    acc[ch] = acc[ch] | r_d_val[i][ch*CH_W +: CH_W];
                end
            end
        end
        med.med_red   = acc[0];
        med.med_green = acc[1];
        med.med_blue  = acc[2];
        med.row_end   = r_d_last;
    end

    // ---------------- result queue with credits ----------------
    t_result          r_fifo [FIFO_DEPTH];
    logic [FPW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FCW-1:0]   r_fcnt, r_cred;
    logic             pop;

    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_fcnt != '0);
    assign o_in_ready  = (r_cred < FCW'(FIFO_DEPTH));
    assign o_med_red   = r_fifo[r_rd_ptr].med_red;
    assign o_med_green = r_fifo[r_rd_ptr].med_green;
    assign o_med_blue  = r_fifo[r_rd_ptr].med_blue;
    assign o_row_end   = r_fifo[r_rd_ptr].row_end;

    // Reserve a slot per emitting beat at accept, release on pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcnt   <= '0;
            r_cred   <= '0;
        end else begin
            if (r_d_valid) begin
                r_wr_ptr <= (r_wr_ptr == FPW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + FPW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == FPW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + FPW'(1);
            end
            r_fcnt <= r_fcnt + FCW'(r_d_valid) - FCW'(pop);
            r_cred <= r_cred + FCW'(accept && emit) - FCW'(pop);
        end
        if (r_d_valid) begin
            r_fifo[r_wr_ptr] <= med;
        end
    end

    // ---------------- assertions ----------------
    a_cred_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cred <= FCW'(FIFO_DEPTH))
        else $error("credit count exceeds queue depth");

    a_fill_le_cred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_cred)
        else $error("queue holds more results than reserved");

    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> $past(r_b_valid))
        else $error("bypass selected without a pending line store write");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid |-> (r_fcnt < FCW'(FIFO_DEPTH)) || pop)
        else $error("result pushed into a full queue");

endmodule

[sv/mf5_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mf5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
